/* hdl/ilir_pkg.sv */
package ilir_pkg;

	localparam int DEPTH   = 64;
	localparam int VAL_W   = 32;
	localparam int OP_W    = 3;
	localparam int POS_W   = 7;
	localparam int ST_W    = 2;
	localparam int COUNT_W = 7;
	localparam int LEN_W   = $clog2(DEPTH + 1);
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W   = (LEN_W > POS_W) ? LEN_W : POS_W;
	localparam int GRP     = 8;
	localparam int NGRP    = (DEPTH + GRP - 1) / GRP;

	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OP_W-1:0] OP_SET    = 3'd2;
	localparam logic [OP_W-1:0] OP_GET    = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic             ins;
		logic             rem;
		logic             set;
		logic             get;
		logic [CMP_W-1:0] pos;
		logic [VAL_W-1:0] value;
	} cell_ctl_t;

endpackage

/* hdl/ilir_if.sv */
interface ilir_req_if import ilir_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         operation;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, output operation, output position, output value,
		input ready);
	modport sink (input valid, input operation, input position, input value,
		output ready);
endinterface

interface ilir_rsp_if import ilir_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [ST_W-1:0]         status;
	logic signed [VAL_W-1:0] read_value;
	logic [COUNT_W-1:0]      count;

	modport source (output valid, output status, output read_value, output count,
		input ready);
	modport sink (input valid, input status, input read_value, input count,
		output ready);
endinterface

/* hdl/ilir_cell.sv */
module ilir_cell import ilir_pkg::*; (
	input  logic             clk,
	input  logic [IDX_W-1:0] idx,
	input  cell_ctl_t        ctl,
	input  logic [VAL_W-1:0] left_data,
	input  logic [VAL_W-1:0] right_data,
	output logic [VAL_W-1:0] data,
	output logic [VAL_W-1:0] rd_data
);

	logic [VAL_W-1:0] data_q;
	logic [CMP_W-1:0] idx_ext;
	logic             at_pos;
	logic             above;

	assign idx_ext = CMP_W'(idx);
	assign at_pos  = idx_ext == ctl.pos;
	assign above   = idx_ext > ctl.pos;

	always_ff @(posedge clk) begin
		if (ctl.ins && above) begin
			data_q <= left_data;
		end else if ((ctl.ins || ctl.set) && at_pos) begin
			data_q <= ctl.value;
		end else if (ctl.rem && (above || at_pos)) begin
			data_q <= right_data;
		end
	end

	assign data    = data_q;
	assign rd_data = (ctl.get && at_pos) ? data_q : '0;

endmodule

/* hdl/indexed_list_insert_remove.sv */
// Positional list of up to DEPTH signed 32-bit values held in a row of cells.
// req channel (sink): operation, position, value. rsp channel (source):
// status, read_value, count. A transfer happens when valid and ready are high
// at a rising edge of clk.
// Every request gives one response. Insert, remove and set update the cells
// at the edge that accepts the request; clear only resets the length. Each
// cell loads its left or right neighbor, the request value, or holds. Get
// reads the addressed cell through a two-level OR tree, one level registered.
// The response passes through the read stage and then the output register.
// Throughput: one request per cycle while rsp is taken; the cell row updates
// once per request and the read tree adds one stage.
// Reset (arst_n low, asynchronous) empties the list and drops any pending
// response; cell contents are left as they are.
// When the receiver stalls, the response holds in the output register, one
// more request may be taken into the read stage, and req.ready then drops
// until the output register frees.
module indexed_list_insert_remove import ilir_pkg::*; (
	input logic clk,
	input logic arst_n,
	ilir_req_if.sink   req,
	ilir_rsp_if.source rsp
);

	logic [LEN_W-1:0] length_q;
	logic [LEN_W-1:0] len_nxt;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] len_ext;
	logic [ST_W-1:0]  st_nxt;
	logic             accept;
	logic             full;
	cell_ctl_t        ctl;

	logic [VAL_W-1:0] cell_data [DEPTH];
	logic [VAL_W-1:0] cell_rd [DEPTH];
	logic [VAL_W-1:0] grp_or [NGRP];

	logic               s1_v_q;
	logic [ST_W-1:0]    status_s1;
	logic [COUNT_W-1:0] count_s1;
	logic [VAL_W-1:0]   grp_s1 [NGRP];
	logic               s1_adv;
	logic [VAL_W-1:0]   rd_or;

	logic               out_v_q;
	logic [ST_W-1:0]    status_q;
	logic [VAL_W-1:0]   read_value_q;
	logic [COUNT_W-1:0] count_q;

	assign accept  = req.valid && req.ready;
	assign pos_ext = CMP_W'(req.position);
	assign len_ext = CMP_W'(length_q);
	assign full    = length_q == LEN_W'(DEPTH);

	always_comb begin
		ctl       = '0;
		ctl.pos   = pos_ext;
		ctl.value = req.value;
		st_nxt    = ST_OK;
		len_nxt   = length_q;
		case (req.operation)
			OP_INSERT: begin
				if (pos_ext > len_ext) begin
					st_nxt = ST_RANGE;
				end else if (full) begin
					st_nxt = ST_FULL;
				end else begin
					ctl.ins = accept;
					len_nxt = length_q + LEN_W'(1);
				end
			end
			OP_REMOVE: begin
				if (pos_ext >= len_ext) begin
					st_nxt = ST_RANGE;
				end else begin
					ctl.rem = accept;
					len_nxt = length_q - LEN_W'(1);
				end
			end
			OP_SET: begin
				if (pos_ext >= len_ext) begin
					st_nxt = ST_RANGE;
				end else begin
					ctl.set = accept;
				end
			end
			OP_GET: begin
				if (pos_ext >= len_ext) begin
					st_nxt = ST_RANGE;
				end else begin
					ctl.get = 1'b1;
				end
			end
			OP_CLEAR: begin
				len_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] left_d;
		logic [VAL_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = req.value;
		end else begin : g_left
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_right
			assign right_d = cell_data[i+1];
		end
		ilir_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(i)),
			.ctl        (ctl),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.rd_data    (cell_rd[i])
		);
	end

	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		always_comb begin
			grp_or[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < DEPTH) begin
					grp_or[g] = grp_or[g] | cell_rd[g * GRP + k];
				end
			end
		end
	end

	always_comb begin
		rd_or = '0;
		for (int g = 0; g < NGRP; g++) begin
			rd_or = rd_or | grp_s1[g];
		end
	end

	assign s1_adv    = s1_v_q && (!out_v_q || rsp.ready);
	assign req.ready = !s1_v_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
			s1_v_q   <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (accept) begin
				length_q <= len_nxt;
			end
			if (accept) begin
				s1_v_q <= 1'b1;
			end else if (s1_adv) begin
				s1_v_q <= 1'b0;
			end
			if (s1_adv) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= st_nxt;
			count_s1  <= COUNT_W'(CMP_W'(len_nxt));
			grp_s1    <= grp_or;
		end
		if (s1_adv) begin
			status_q     <= status_s1;
			count_q      <= count_s1;
			read_value_q <= rd_or;
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.status     = status_q;
	assign rsp.count      = count_q;
	assign rsp.read_value = $signed(read_value_q);

endmodule

/* hdl/ilir_chk.sv */
module ilir_chk import ilir_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [ST_W-1:0]    rsp_status,
	input logic [VAL_W-1:0]   rsp_read_value,
	input logic [COUNT_W-1:0] rsp_count
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_read_value) && $stable(rsp_count))
		else $error("response changed while stalled");

	a_rsp_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> ##2 rsp_valid)
		else $error("no response two cycles after request transfer");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_read_value == '0)
		else $error("nonzero read value on error status");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_count == COUNT_W'(DEPTH))
		else $error("full status with list not full");

endmodule

bind indexed_list_insert_remove ilir_chk u_ilir_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_read_value (rsp.read_value),
	.rsp_count      (rsp.count)
);

/* tb/tb_indexed_list_insert_remove.sv */
module tb_indexed_list_insert_remove;
	import ilir_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;
	localparam int ITEM_TARGET = 1850;
	localparam int POS_MAX = (1 << POS_W) - 1;

	typedef struct packed {
		logic [ST_W-1:0]         status;
		logic signed [VAL_W-1:0] read_value;
		logic [COUNT_W-1:0]      count;
	} list_rsp_t;

	typedef struct packed {
		bit        typed;
		list_rsp_t want;
	} rsp_tag_t;

	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] val;
		bit                      typed;
		list_rsp_t               want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	ilir_req_if req_ch ();
	ilir_rsp_if rsp_ch ();

	indexed_list_insert_remove DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// list contents as the block should hold them
	logic signed [VAL_W-1:0] list_mem [DEPTH];
	int                      list_len = 0;

	list_rsp_t expected_rsp [$];
	rsp_tag_t  rsp_tag_q [$];

	int  plan_len = 0;
	int  sent = 0;
	int  accepted = 0;
	int  answered = 0;
	int  err_count = 0;
	int  seen_ok = 0;
	int  seen_range = 0;
	int  seen_full = 0;
	bit  calm = 1'b0;
	int unsigned stall_left = 0;

	function automatic list_rsp_t apply_list_request(logic [OP_W-1:0] op,
			logic [POS_W-1:0] pos, logic signed [VAL_W-1:0] val);
		list_rsp_t r;
		int        p;
		int        i;
		r = '{status: ST_OK, read_value: '0, count: '0};
		p = int'(pos);
		case (op)
			OP_INSERT: begin
				if (p > list_len) begin
					r.status = ST_RANGE;
				end else if (list_len >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (i = list_len; i > p; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[p] = val;
					list_len++;
				end
			end
			OP_REMOVE: begin
				if (p >= list_len) begin
					r.status = ST_RANGE;
				end else begin
					for (i = p; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			OP_SET: begin
				if (p >= list_len)
					r.status = ST_RANGE;
				else
					list_mem[p] = val;
			end
			OP_GET: begin
				if (p >= list_len)
					r.status = ST_RANGE;
				else
					r.read_value = list_mem[p];
			end
			OP_CLEAR: list_len = 0;
			default: ;
		endcase
		r.count = COUNT_W'(list_len);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		if (err_count < 50)
			$display("MISMATCH at %0t, response %0d: %s", $realtime, answered, msg);
		err_count++;
	endtask

	always @(posedge clk) begin
		list_rsp_t model;
		list_rsp_t want;
		rsp_tag_t  tag;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			model = apply_list_request(req_ch.operation, req_ch.position, req_ch.value);
			tag = rsp_tag_q.pop_front();
			expected_rsp.push_back(tag.typed ? tag.want : model);
			accepted++;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsp.size() == 0) begin
				report_mismatch("response with no request outstanding");
			end else begin
				want = expected_rsp.pop_front();
				if (rsp_ch.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						rsp_ch.status, want.status));
				if (rsp_ch.read_value !== want.read_value)
					report_mismatch($sformatf("read_value %0h, want %0h",
						rsp_ch.read_value, want.read_value));
				if (rsp_ch.count !== want.count)
					report_mismatch($sformatf("count %0d, want %0d",
						rsp_ch.count, want.count));
				case (want.status)
					ST_OK: seen_ok++;
					ST_RANGE: seen_range++;
					default: seen_full++;
				endcase
			end
			answered++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_ch.ready <= (stall_left == 1);
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 19);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	task automatic send_request(input logic [OP_W-1:0] op, input int pos,
			input logic signed [VAL_W-1:0] val, input bit typed = 1'b0,
			input list_rsp_t want = '0);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 19);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rsp_tag_q.push_back('{typed: typed, want: want});
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.position  <= POS_W'(pos);
		req_ch.value     <= val;
		do
			@(posedge clk);
		while (!req_ch.ready);
		case (op)
			OP_INSERT: if (pos <= plan_len && plan_len < DEPTH) plan_len++;
			OP_REMOVE: if (pos < plan_len) plan_len--;
			OP_CLEAR: plan_len = 0;
			default: ;
		endcase
		sent++;
	endtask

	function automatic int pick_slot(bit for_insert);
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(0, POS_MAX);
		if (for_insert)
			return $urandom_range(0, plan_len);
		return (plan_len == 0) ? 0 : $urandom_range(0, plan_len - 1);
	endfunction

	dir_row_t dir_rows [25] = '{
		'{OP_GET,     7'd0,   32'sd0,         1'b1, '{ST_RANGE, 32'sd0, 7'd0}},
		'{OP_REMOVE,  7'd0,   32'sd0,         1'b1, '{ST_RANGE, 32'sd0, 7'd0}},
		'{OP_SET,     7'd0,   32'sd5,         1'b1, '{ST_RANGE, 32'sd0, 7'd0}},
		'{OP_INSERT,  7'd1,   32'sd9,         1'b1, '{ST_RANGE, 32'sd0, 7'd0}},
		'{OP_INSERT,  7'd0,   32'h8000_0000,  1'b1, '{ST_OK, 32'sd0, 7'd1}},
		'{OP_INSERT,  7'd1,   32'h7FFF_FFFF,  1'b1, '{ST_OK, 32'sd0, 7'd2}},
		'{OP_GET,     7'd0,   32'sd0,         1'b1, '{ST_OK, 32'h8000_0000, 7'd2}},
		'{OP_GET,     7'd1,   32'sd0,         1'b1, '{ST_OK, 32'h7FFF_FFFF, 7'd2}},
		'{OP_GET,     7'd2,   32'sd0,         1'b1, '{ST_RANGE, 32'sd0, 7'd2}},
		'{OP_INSERT,  7'd127, 32'hFFFF_FFFF,  1'b1, '{ST_RANGE, 32'sd0, 7'd2}},
		'{OP_REMOVE,  7'd64,  32'sd0,         1'b1, '{ST_RANGE, 32'sd0, 7'd2}},
		'{OP_SET,     7'd0,   32'hFFFF_FFFF,  1'b1, '{ST_OK, 32'sd0, 7'd2}},
		'{OP_SPARE_A, 7'd0,   32'sd1,         1'b1, '{ST_OK, 32'sd0, 7'd2}},
		'{OP_SPARE_B, 7'd127, 32'hFFFF_FFFF,  1'b1, '{ST_OK, 32'sd0, 7'd2}},
		'{OP_SPARE_C, 7'd1,   32'sd0,         1'b1, '{ST_OK, 32'sd0, 7'd2}},
		'{OP_INSERT,  7'd1,   32'h5A5A_5A5A,  1'b0, '0},
		'{OP_INSERT,  7'd0,   32'sd1,         1'b0, '0},
		'{OP_GET,     7'd3,   32'sd0,         1'b0, '0},
		'{OP_REMOVE,  7'd1,   32'sd0,         1'b0, '0},
		'{OP_GET,     7'd1,   32'sd0,         1'b0, '0},
		'{OP_SET,     7'd2,   32'h1234_5678,  1'b0, '0},
		'{OP_GET,     7'd2,   32'sd0,         1'b0, '0},
		'{OP_CLEAR,   7'd0,   32'sd0,         1'b1, '{ST_OK, 32'sd0, 7'd0}},
		'{OP_GET,     7'd0,   32'sd0,         1'b1, '{ST_RANGE, 32'sd0, 7'd0}},
		'{OP_INSERT,  7'd2,   32'sd3,         1'b1, '{ST_RANGE, 32'sd0, 7'd0}}
	};

	initial begin
		int                 kind;
		int                 n;
		int                 r;
		int                 settle;
		logic [OP_W-1:0]    op;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_GET;
		req_ch.position  = '0;
		req_ch.value     = '0;
		for (int i = 0; i < DEPTH; i++)
			list_mem[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].op, dir_rows[i].pos, dir_rows[i].val,
				dir_rows[i].typed, dir_rows[i].want);

		kind = 5;
		while (sent < ITEM_TARGET) begin
			calm = (sent >= ITEM_TARGET - 150) || ($urandom_range(0, 3) == 0);
			if (kind <= 4) begin
				n = $urandom_range(10, 40);
				repeat (n) begin
					r = $urandom_range(0, 99);
					if (r < 35) op = OP_INSERT;
					else if (r < 55) op = OP_REMOVE;
					else if (r < 70) op = OP_SET;
					else if (r < 95) op = OP_GET;
					else if (r < 97) op = OP_CLEAR;
					else op = OP_SPARE_A + OP_W'($urandom_range(0, 2));
					send_request(op, pick_slot(op == OP_INSERT), $urandom);
				end
			end else if (kind <= 6) begin
				// fill to the brim, then poke the edges of a full list
				while (plan_len < DEPTH)
					send_request(OP_INSERT, $urandom_range(0, plan_len), $urandom);
				send_request(OP_INSERT, $urandom_range(0, DEPTH), $urandom);
				send_request(OP_INSERT, $urandom_range(DEPTH + 1, POS_MAX), $urandom);
				send_request(OP_GET, DEPTH - 1, $urandom);
				send_request(OP_SET, DEPTH - 1, $urandom);
				send_request(OP_GET, DEPTH - 1, $urandom);
				send_request(OP_GET, DEPTH, $urandom);
				send_request(OP_REMOVE, DEPTH, $urandom);
				send_request(OP_REMOVE, DEPTH - 1, $urandom);
				send_request(OP_INSERT, DEPTH - 1, $urandom);
			end else if (kind <= 8) begin
				n = $urandom_range(1, plan_len + 2);
				repeat (n) begin
					send_request(OP_REMOVE, pick_slot(1'b0), $urandom);
					if ($urandom_range(0, 1) == 0)
						send_request(OP_GET, pick_slot(1'b0), $urandom);
				end
			end else begin
				n = $urandom_range(5, 20);
				repeat (n)
					send_request(OP_W'($urandom_range(0, 7)),
						$urandom_range(0, POS_MAX), $urandom);
			end
			kind = $urandom_range(0, 9);
		end
		req_ch.valid <= 1'b0;

		settle = 0;
		while (expected_rsp.size() != 0 && settle < 5000) begin
			@(posedge clk);
			settle++;
		end
		repeat (10) @(posedge clk);
		if (expected_rsp.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived", expected_rsp.size()));

		$display("Sent %0d requests, %0d accepted, %0d responses checked.",
			sent, accepted, answered);
		$display("Statuses seen: %0d ok, %0d out of range, %0d list full; %0d mismatches.",
			seen_ok, seen_range, seen_full, err_count);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
